@@ rtl/stdpcm_pkg.sv @@
// ----------------------------------------------------------------------------
// stdpcm_pkg
// Shared widths, request codes and adder request types for the stereo
// table DPCM encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package stdpcm_pkg;

    // step table size and field widths
    localparam int TABLE_ENTRIES = 256;
    localparam int SAMPLE_W      = 16;
    localparam int STEP_W        = 16;
    localparam int PRED_W        = 17;
    localparam int ALU_W         = 18;

    // predictor saturation bound (magnitude)
    localparam int PRED_LIMIT    = 32768;

    // request kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_ENCODE = 1'b1;

    // operands for the shared add/subtract unit
    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } t_alu_req;

    // result and flags of the shared add/subtract unit
    typedef struct packed {
        logic signed [ALU_W-1:0] sum;
        logic                    neg;
        logic                    zero;
    } t_alu_rsp;

endpackage

`default_nettype wire

@@ rtl/stdpcm_alu.sv @@
// ----------------------------------------------------------------------------
// stdpcm_alu
// Shared 18-bit add/subtract unit with sign and zero flags, used for the
// sample difference, every table compare and the predictor update.
// ----------------------------------------------------------------------------
`default_nettype none

module stdpcm_alu (
    input  var stdpcm_pkg::t_alu_req i_req,
    output var stdpcm_pkg::t_alu_rsp o_rsp
);

    logic signed [stdpcm_pkg::ALU_W-1:0] sum;

    // a - b or a + b
    always_comb begin
        if (i_req.sub) begin
            sum = i_req.a - i_req.b;
        end else begin
            sum = i_req.a + i_req.b;
        end
    end

    // result with sign and zero flags
    always_comb begin
        o_rsp.sum  = sum;
        o_rsp.neg  = sum[stdpcm_pkg::ALU_W-1];
        o_rsp.zero = (sum == '0);
    end

endmodule

`default_nettype wire

@@ rtl/stereo_table_dpcm_encoder.sv @@
// ----------------------------------------------------------------------------
// stereo_table_dpcm_encoder
// Stereo DPCM encoder with a loadable 256-entry step table and one
// saturating predictor per channel.
// ----------------------------------------------------------------------------
// A table-write request is accepted while idle and gives no result. An encode
// request forms the difference to the channel's predictor and then scans the
// step table outward from the middle entry, one entry per cycle through the
// single table read port and one shared add/subtract unit used as the
// comparator. An encode with a zero difference skips the scan; otherwise it
// makes up to 129 compares. Then the chosen step is read and, once the output
// register is free, the predictor is updated. The input is not ready while an
// encode is in progress; one finished result can wait in the output register
// while the next request is accepted. Entries must be written before an
// encode reads them. A predictor that would leave -32768..32768 is saturated
// and the result carries out_of_range.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_table_dpcm_encoder #(
    parameter int TABLE_ENTRIES = stdpcm_pkg::TABLE_ENTRIES
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output var  logic                                   o_in_ready,
    input  wire logic                                   i_kind,
    input  wire logic                                   i_channel,
    input  wire logic signed [stdpcm_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]       i_entry_index,
    input  wire logic signed [stdpcm_pkg::STEP_W-1:0]   i_entry_value,
    output var  logic                                   o_out_valid,
    input  wire logic                                   i_out_ready,
    output var  logic [$clog2(TABLE_ENTRIES)-1:0]       o_code,
    output var  logic                                   o_out_of_range
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int ALU_W  = stdpcm_pkg::ALU_W;
    localparam int PRED_W = stdpcm_pkg::PRED_W;
    localparam int STEP_W = stdpcm_pkg::STEP_W;

    localparam logic [IDX_W-1:0] IDX_MID  = IDX_W'(TABLE_ENTRIES / 2);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;

    localparam logic signed [ALU_W-1:0] LIM_HI = ALU_W'(stdpcm_pkg::PRED_LIMIT);
    localparam logic signed [ALU_W-1:0] LIM_LO = -LIM_HI;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_ADD   = 2'd3;

    logic [1:0]               r_state,     n_state;
    logic [IDX_W-1:0]         r_addr,      n_addr;
    logic [IDX_W-1:0]         r_cmp_idx,   n_cmp_idx;
    logic                     r_cmp_vld,   n_cmp_vld;
    logic signed [ALU_W-1:0]  r_diff,      n_diff;
    logic                     r_neg,       n_neg;
    logic                     r_chan,      n_chan;
    logic [IDX_W-1:0]         r_code,      n_code;
    logic signed [PRED_W-1:0] r_pred_l,    n_pred_l;
    logic signed [PRED_W-1:0] r_pred_r,    n_pred_r;
    logic                     r_out_valid, n_out_valid;
    logic [IDX_W-1:0]         r_out_code,  n_out_code;
    logic                     r_oor,       n_oor;

    logic signed [STEP_W-1:0] r_step_mem [TABLE_ENTRIES];
    logic signed [STEP_W-1:0] r_rd_data;
    logic [IDX_W-1:0]         rd_addr;
    logic                     tbl_we;

    stdpcm_pkg::t_alu_req     alu_req;
    stdpcm_pkg::t_alu_rsp     alu_rsp;

    logic signed [PRED_W-1:0] pred_sel;
    logic signed [ALU_W-1:0]  sum_s;
    logic signed [ALU_W-1:0]  sat_sum;
    logic                     sat_flag;
    logic                     out_free;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_code         = r_out_code;
    assign o_out_of_range = r_oor;

    assign out_free = !r_out_valid || i_out_ready;
    assign pred_sel = (r_state == S_IDLE) ? (i_channel ? r_pred_r : r_pred_l)
                                          : (r_chan ? r_pred_r : r_pred_l);

    // shared add/subtract unit
    stdpcm_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // operand select per sequencer step
    always_comb begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(i_sample);
        alu_req.b   = ALU_W'(pred_sel);
        case (r_state)
            S_IDLE: begin
                alu_req.a = ALU_W'(i_sample);
                alu_req.b = ALU_W'(pred_sel);
            end
            S_SCAN: begin
                // negative side hits when entry < d, positive when entry > d
                if (r_neg) begin
                    alu_req.a = ALU_W'(r_rd_data);
                    alu_req.b = r_diff;
                end else begin
                    alu_req.a = r_diff;
                    alu_req.b = ALU_W'(r_rd_data);
                end
            end
            S_ADD: begin
                alu_req.sub = 1'b0;
                alu_req.a   = ALU_W'(pred_sel);
                alu_req.b   = ALU_W'(r_rd_data);
            end
            default: begin
                alu_req.sub = 1'b1;
            end
        endcase
    end

    // predictor saturation
    always_comb begin
        sum_s    = $signed(alu_rsp.sum);
        sat_sum  = sum_s;
        sat_flag = 1'b0;
        if (sum_s > LIM_HI) begin
            sat_sum  = LIM_HI;
            sat_flag = 1'b1;
        end else if (sum_s < LIM_LO) begin
            sat_sum  = LIM_LO;
            sat_flag = 1'b1;
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_diff      = r_diff;
        n_neg       = r_neg;
        n_chan      = r_chan;
        n_code      = r_code;
        n_pred_l    = r_pred_l;
        n_pred_r    = r_pred_r;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_code  = r_out_code;
        n_oor       = r_oor;
        rd_addr     = r_addr;
        tbl_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == stdpcm_pkg::KIND_WRITE) begin
                        tbl_we = 1'b1;
                    end else begin
                        n_chan    = i_channel;
                        n_diff    = alu_rsp.sum;
                        n_neg     = alu_rsp.neg;
                        n_addr    = IDX_MID;
                        n_cmp_vld = 1'b0;
                        if (alu_rsp.zero) begin
                            n_code  = IDX_MID;
                            n_state = S_FETCH;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // read one entry a cycle, compare the one read last cycle
                n_addr    = r_neg ? (r_addr - IDX_ONE) : (r_addr + IDX_ONE);
                n_cmp_idx = r_addr;
                n_cmp_vld = 1'b1;
                if (r_cmp_vld) begin
                    if (alu_rsp.neg) begin
                        n_code  = r_neg ? (r_cmp_idx + IDX_ONE) : (r_cmp_idx - IDX_ONE);
                        n_state = S_FETCH;
                    end else if (!r_neg && r_cmp_idx == IDX_LAST) begin
                        n_code  = IDX_LAST;
                        n_state = S_FETCH;
                    end else if (r_neg && r_cmp_idx == IDX_ZERO) begin
                        n_code  = IDX_ONE;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                rd_addr = r_code;
                n_state = S_ADD;
            end
            S_ADD: begin
                rd_addr = r_code;
                if (out_free) begin
                    if (r_chan) begin
                        n_pred_r = sat_sum[PRED_W-1:0];
                    end else begin
                        n_pred_l = sat_sum[PRED_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_out_code  = r_code;
                    n_oor       = sat_flag;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_pred_l    <= '0;
            r_pred_r    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_pred_l    <= n_pred_l;
            r_pred_r    <= n_pred_r;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_cmp_idx  <= n_cmp_idx;
        r_diff     <= n_diff;
        r_neg      <= n_neg;
        r_chan     <= n_chan;
        r_code     <= n_code;
        r_out_code <= n_out_code;
        r_oor      <= n_oor;
    end

    // step table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_step_mem[i_entry_index] <= i_entry_value;
        end
        r_rd_data <= r_step_mem[rd_addr];
    end

`ifndef SYNTH
    // predictors never leave the saturation range
    a_pred_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed(ALU_W'(r_pred_l)) <= LIM_HI) && ($signed(ALU_W'(r_pred_l)) >= LIM_LO) &&
        ($signed(ALU_W'(r_pred_r)) <= LIM_HI) && ($signed(ALU_W'(r_pred_r)) >= LIM_LO))
        else $error("predictor out of saturation range");

    // a flagged result leaves its predictor at a bound
    a_oor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && r_oor) |->
        ((r_chan ? $signed(ALU_W'(r_pred_r)) : $signed(ALU_W'(r_pred_l))) == LIM_HI ||
         (r_chan ? $signed(ALU_W'(r_pred_r)) : $signed(ALU_W'(r_pred_l))) == LIM_LO))
        else $error("out_of_range set without saturated predictor");

    // no code zero is ever chosen
    a_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_code != IDX_ZERO))
        else $error("code zero chosen");

    // an accepted encode never produces its result in the next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == stdpcm_pkg::KIND_ENCODE)
        |=> !$rose(r_out_valid))
        else $error("result too early");

    // a table write leaves the sequencer idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == stdpcm_pkg::KIND_WRITE)
        |=> (r_state == S_IDLE))
        else $error("table write started a sequence");
`endif

endmodule

`default_nettype wire
